// ===== rtl/core/lfpd_pkg.sv =====
// Shared types, widths, codes and reset values for the line follower PD drive unit.
// Every module of the block imports this package; it depends on nothing else.
package lfpd_pkg;

    localparam int SENSOR_COUNT = 5;
    localparam int SAMPLE_W     = 10;
    localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);
    localparam int WSUM_MAX     = SENSOR_COUNT * (SENSOR_COUNT + 1) / 2;
    localparam int WSUM_W       = $clog2(WSUM_MAX + 1);
    localparam int QUO_W        = CNT_W;
    localparam int CENTRE_IDX   = SENSOR_COUNT / 2;

    localparam int POS_W    = 3;
    localparam int ERR_W    = POS_W + 1;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int GAIN_W   = 10;
    localparam int SPEED_W  = 8;
    localparam int MODE_W   = 2;
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
    localparam int PD_W     = PROD_D_W + 1;
    localparam int MOTOR_W  = PD_W + 1;

    localparam int FIFO_DEPTH = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [MODE_W-1:0] MODE_FOLLOW = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SPIN   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ON_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_POSITION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_SPEED      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT     = 3'd6;

    localparam logic [SAMPLE_W-1:0] RST_ON_THRESHOLD    = 10'd600;
    localparam logic [POS_W-1:0]    RST_TARGET_POSITION = 3'd3;
    localparam logic [GAIN_W-1:0]   RST_PROP_GAIN       = 10'd190;
    localparam logic [GAIN_W-1:0]   RST_DERIV_GAIN      = 10'd500;
    localparam logic [SPEED_W-1:0]  RST_CRUISE_SPEED    = 8'd120;
    localparam logic [SPEED_W-1:0]  RST_SPIN_SPEED      = 8'd120;
    localparam logic [SPEED_W-1:0]  RST_DRIVE_LIMIT     = 8'd200;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // One classified sensor set, as handed from the front to the back.
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [WSUM_W-1:0] wsum;
        logic              centre_on;
        logic              first_on;
        logic              last_on;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]   target_position;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [SPEED_W-1:0] cruise_speed;
        logic [SPEED_W-1:0] spin_speed;
        logic [SPEED_W-1:0] drive_limit;
    } drive_cfg_t;

endpackage

// ===== rtl/core/lfpd_front.sv =====
// Front end: takes a sensor set, thresholds each sample, counts and weights the on sensors.
// Depends on lfpd_pkg; pushes classified items into lfpd_fifo.
module lfpd_front (
    input  logic              sensor_valid,
    output logic              sensor_ready,
    input  lfpd_pkg::sample_t samples [lfpd_pkg::SENSOR_COUNT],
    input  lfpd_pkg::sample_t on_threshold,
    input  logic              fifo_full,
    output logic              push,
    output lfpd_pkg::item_t   item
);
    import lfpd_pkg::*;

    logic [SENSOR_COUNT-1:0] on_vec;
    logic [CNT_W-1:0]        cnt_sum;
    logic [WSUM_W-1:0]       wsum_acc;

    always_comb
    begin
        cnt_sum  = '0;
        wsum_acc = '0;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            on_vec[i] = samples[i] > on_threshold;
            cnt_sum   = cnt_sum + CNT_W'(on_vec[i]);
            if (on_vec[i])
            begin
                wsum_acc = wsum_acc + WSUM_W'(i + 1);
            end
        end
    end

    assign item.count     = cnt_sum;
    assign item.wsum      = wsum_acc;
    assign item.centre_on = on_vec[CENTRE_IDX];
    assign item.first_on  = on_vec[0];
    assign item.last_on   = on_vec[SENSOR_COUNT-1];

    assign sensor_ready = !fifo_full;
    assign push         = sensor_valid && !fifo_full;

endmodule

// ===== rtl/core/lfpd_fifo.sv =====
// Short item queue between the front end and the drive back end.
// Depends on lfpd_pkg for the item type and depth.
module lfpd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lfpd_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output lfpd_pkg::item_t head
);
    import lfpd_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);

    item_t             entries_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_FW-1:0] count_reg;
    logic [CNT_FW-1:0] count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(FIFO_DEPTH - 1))
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign full  = count_reg == CNT_FW'(FIFO_DEPTH);
    assign valid = count_reg != '0;
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_FW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/lfpd_div.sv =====
// Bit-serial restoring divider for the weighted line position, one quotient bit per cycle.
// Depends on lfpd_pkg for operand widths.
module lfpd_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lfpd_pkg::WSUM_W-1:0] dividend,
    input  logic [lfpd_pkg::CNT_W-1:0]  divisor,
    output logic                       last,
    output logic [lfpd_pkg::QUO_W-1:0]  quotient
);
    import lfpd_pkg::*;

    localparam int IDX_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;
    localparam int PW    = WSUM_W + QUO_W;

    logic              active_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [WSUM_W-1:0] rem_reg;
    logic [CNT_W-1:0]  dsr_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic [PW-1:0]     shifted;
    logic              fits;
    logic [WSUM_W-1:0] rem_sub;

    // The quotient never exceeds the largest weight, so QUO_W steps cover it.
    assign shifted = PW'(dsr_reg) << idx_reg;
    assign fits    = PW'(rem_reg) >= shifted;
    assign rem_sub = rem_reg - shifted[WSUM_W-1:0];

    assign last     = active_reg && (idx_reg == '0);
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            idx_reg    <= IDX_W'(QUO_W - 1);
        end
        else if (active_reg)
        begin
            if (idx_reg == '0)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsr_reg <= divisor;
            quo_reg <= '0;
        end
        else if (active_reg && fits)
        begin
            rem_reg          <= rem_sub;
            quo_reg[idx_reg] <= 1'b1;
        end
    end

endmodule

// ===== rtl/core/lfpd_back.sv =====
// Back end: drive mode sequencing, position divide, PD gain multiplies and motor outputs.
// Depends on lfpd_pkg and lfpd_div; pops items from lfpd_fifo and owns the result register.
module lfpd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fifo_valid,
    input  lfpd_pkg::item_t             fifo_head,
    output logic                        fifo_pop,
    input  lfpd_pkg::drive_cfg_t        cfg,
    output logic                        drive_valid,
    input  logic                        drive_ready,
    output logic                        left_forward,
    output logic [lfpd_pkg::SPEED_W-1:0] left_drive,
    output logic                        right_forward,
    output logic [lfpd_pkg::SPEED_W-1:0] right_drive,
    output logic [lfpd_pkg::MODE_W-1:0]  drive_mode,
    output logic [lfpd_pkg::CNT_W-1:0]   sensors_on
);
    import lfpd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_SUM  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Architectural state, committed when the result is written.
    logic [MODE_W-1:0]       mode_reg;
    logic [POS_W-1:0]        held_reg;
    logic signed [ERR_W-1:0] prior_err_reg;
    logic                    last_right_reg;

    item_t                      item_reg;
    logic [POS_W-1:0]           held_new_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [PROD_P_W-1:0] prod_p_reg;
    logic signed [PROD_D_W-1:0] prod_d_reg;
    logic                       do_pd_reg;
    logic [MODE_W-1:0]          mode_new_reg;

    logic               out_valid_reg;
    logic               left_forward_reg;
    logic [SPEED_W-1:0] left_drive_reg;
    logic               right_forward_reg;
    logic [SPEED_W-1:0] right_drive_reg;
    logic [MODE_W-1:0]  drive_mode_reg;
    logic [CNT_W-1:0]   sensors_on_reg;

    logic             out_free;
    logic             load;
    logic             commit;
    logic             div_last;
    logic [QUO_W-1:0] div_quo;

    logic [POS_W-1:0]           held_new;
    logic signed [ERR_W-1:0]    err_c;
    logic signed [DIFF_W-1:0]   diff_c;
    logic signed [PROD_P_W-1:0] prod_p_c;
    logic signed [PROD_D_W-1:0] prod_d_c;
    logic                       do_pd_c;
    logic [MODE_W-1:0]          mode_new_c;

    logic signed [MOTOR_W-1:0] pd_s;
    logic signed [MOTOR_W-1:0] cruise_s;
    logic signed [MOTOR_W-1:0] spin_s;
    logic signed [MOTOR_W-1:0] left_v;
    logic signed [MOTOR_W-1:0] right_v;
    logic [SPEED_W:0]          left_out;
    logic [SPEED_W:0]          right_out;
    logic                      last_right_next;

    // Direction bit on top, saturated magnitude below.
    function automatic logic [SPEED_W:0] motor_out(
        input logic signed [MOTOR_W-1:0] v,
        input logic [SPEED_W-1:0]        limit
    );
        logic [MOTOR_W-1:0] mag;
        logic               fwd;
        fwd = v > 0;
        mag = v[MOTOR_W-1] ? MOTOR_W'(-v) : MOTOR_W'(v);
        if (mag > MOTOR_W'(limit))
        begin
            return {fwd, limit};
        end
        return {fwd, mag[SPEED_W-1:0]};
    endfunction

    lfpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (load),
        .dividend (fifo_head.wsum),
        .divisor  (fifo_head.count),
        .last     (div_last),
        .quotient (div_quo)
    );

    assign out_free = !out_valid_reg || drive_ready;
    assign commit   = (state_reg == S_SUM) && out_free;
    assign load     = fifo_valid && ((state_reg == S_IDLE) || commit);
    assign fifo_pop = load;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fifo_valid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    state_next = fifo_valid ? S_DIV : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Mode decision and gain products, registered at the end of the multiply cycle.
    always_comb
    begin
        held_new = (item_reg.count != '0) ? POS_W'(div_quo) : held_reg;
        err_c    = $signed({1'b0, cfg.target_position}) - $signed({1'b0, held_new});
        diff_c   = $signed({err_c[ERR_W-1], err_c})
                 - $signed({prior_err_reg[ERR_W-1], prior_err_reg});
        prod_p_c = $signed({1'b0, cfg.prop_gain}) * err_c;
        prod_d_c = $signed({1'b0, cfg.deriv_gain}) * diff_c;

        do_pd_c    = 1'b0;
        mode_new_c = mode_reg;
        unique case (mode_reg)
            MODE_STOP:
            begin
                if (item_reg.count != '0)
                begin
                    mode_new_c = MODE_FOLLOW;
                    do_pd_c    = 1'b1;
                end
            end
            MODE_SPIN:
            begin
                if (item_reg.centre_on)
                begin
                    mode_new_c = MODE_FOLLOW;
                    do_pd_c    = 1'b1;
                end
            end
            default:
            begin
                if (item_reg.count == '0)
                begin
                    mode_new_c = MODE_STOP;
                end
                else if (item_reg.count == CNT_W'(SENSOR_COUNT))
                begin
                    mode_new_c = MODE_SPIN;
                end
                else
                begin
                    mode_new_c = MODE_FOLLOW;
                    do_pd_c    = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        pd_s = $signed({{(MOTOR_W-PROD_P_W){prod_p_reg[PROD_P_W-1]}}, prod_p_reg})
             + $signed({{(MOTOR_W-PROD_D_W){prod_d_reg[PROD_D_W-1]}}, prod_d_reg});
        cruise_s = $signed({{(MOTOR_W-SPEED_W){1'b0}}, cfg.cruise_speed});
        spin_s   = $signed({{(MOTOR_W-SPEED_W){1'b0}}, cfg.spin_speed});

        if (do_pd_reg)
        begin
            left_v  = cruise_s + pd_s;
            right_v = cruise_s - pd_s;
        end
        else if (mode_new_reg == MODE_SPIN)
        begin
            left_v  = last_right_reg ? spin_s : -spin_s;
            right_v = last_right_reg ? -spin_s : spin_s;
        end
        else
        begin
            left_v  = '0;
            right_v = '0;
        end

        left_out  = motor_out(left_v, cfg.drive_limit);
        right_out = motor_out(right_v, cfg.drive_limit);

        // The spin above uses the side seen before this item.
        last_right_next = last_right_reg;
        if (item_reg.last_on && !item_reg.first_on)
        begin
            last_right_next = 1'b0;
        end
        else if (!item_reg.last_on && item_reg.first_on)
        begin
            last_right_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_FOLLOW;
            held_reg       <= '0;
            prior_err_reg  <= '0;
            last_right_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg  <= 1'b1;
                mode_reg       <= mode_new_reg;
                held_reg       <= held_new_reg;
                last_right_reg <= last_right_next;
                if (do_pd_reg)
                begin
                    prior_err_reg <= err_reg;
                end
            end
            else if (drive_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= fifo_head;
        end
        if (state_reg == S_MUL)
        begin
            held_new_reg <= held_new;
            err_reg      <= err_c;
            prod_p_reg   <= prod_p_c;
            prod_d_reg   <= prod_d_c;
            do_pd_reg    <= do_pd_c;
            mode_new_reg <= mode_new_c;
        end
        if (commit)
        begin
            left_forward_reg  <= left_out[SPEED_W];
            left_drive_reg    <= left_out[SPEED_W-1:0];
            right_forward_reg <= right_out[SPEED_W];
            right_drive_reg   <= right_out[SPEED_W-1:0];
            drive_mode_reg    <= mode_new_reg;
            sensors_on_reg    <= item_reg.count;
        end
    end

    assign drive_valid   = out_valid_reg;
    assign left_forward  = left_forward_reg;
    assign left_drive    = left_drive_reg;
    assign right_forward = right_forward_reg;
    assign right_drive   = right_drive_reg;
    assign drive_mode    = drive_mode_reg;
    assign sensors_on    = sensors_on_reg;

endmodule

// ===== rtl/core/line_follower_pd_drive_unit.sv =====
// Line follower PD drive unit: configuration registers, front end, item queue and drive back end.
// A sensor set accepted into an empty unit passes the item queue, the bit-serial position
// divider, the gain multiply registers and the result register before its result is valid.
// The back end takes the next item from the queue when it writes a result, after the divide,
// the gain multiplies and the motor sums and saturation. While a result waits on drive_ready,
// three further sets are taken: one into the back end and two into the 2-entry queue.
// Reset returns the config registers to their defaults, mode to following and empties the queue.
module line_follower_pd_drive_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           sensor_valid,
    output logic                           sensor_ready,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]   sensor_0,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]   sensor_1,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]   sensor_2,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]   sensor_3,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]   sensor_4,
    output logic                           drive_valid,
    input  logic                           drive_ready,
    output logic                           left_forward,
    output logic [lfpd_pkg::SPEED_W-1:0]    left_drive,
    output logic                           right_forward,
    output logic [lfpd_pkg::SPEED_W-1:0]    right_drive,
    output logic [lfpd_pkg::MODE_W-1:0]     drive_mode,
    output logic [lfpd_pkg::CNT_W-1:0]      sensors_on
);
    import lfpd_pkg::*;

    logic [SAMPLE_W-1:0] on_threshold_reg;
    logic [POS_W-1:0]    target_position_reg;
    logic [GAIN_W-1:0]   prop_gain_reg;
    logic [GAIN_W-1:0]   deriv_gain_reg;
    logic [SPEED_W-1:0]  cruise_speed_reg;
    logic [SPEED_W-1:0]  spin_speed_reg;
    logic [SPEED_W-1:0]  drive_limit_reg;

    sample_t    samples [SENSOR_COUNT];
    drive_cfg_t drive_cfg;
    item_t      front_item;
    item_t      fifo_head;
    logic       push;
    logic       fifo_full;
    logic       fifo_valid;
    logic       fifo_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_threshold_reg    <= RST_ON_THRESHOLD;
            target_position_reg <= RST_TARGET_POSITION;
            prop_gain_reg       <= RST_PROP_GAIN;
            deriv_gain_reg      <= RST_DERIV_GAIN;
            cruise_speed_reg    <= RST_CRUISE_SPEED;
            spin_speed_reg      <= RST_SPIN_SPEED;
            drive_limit_reg     <= RST_DRIVE_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ON_THRESHOLD:    on_threshold_reg    <= cfg_data[SAMPLE_W-1:0];
                REG_TARGET_POSITION: target_position_reg <= cfg_data[POS_W-1:0];
                REG_PROP_GAIN:       prop_gain_reg       <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:      deriv_gain_reg      <= cfg_data[GAIN_W-1:0];
                REG_CRUISE_SPEED:    cruise_speed_reg    <= cfg_data[SPEED_W-1:0];
                REG_SPIN_SPEED:      spin_speed_reg      <= cfg_data[SPEED_W-1:0];
                REG_DRIVE_LIMIT:     drive_limit_reg     <= cfg_data[SPEED_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign samples[0] = sensor_0;
    assign samples[1] = sensor_1;
    assign samples[2] = sensor_2;
    assign samples[3] = sensor_3;
    assign samples[4] = sensor_4;

    assign drive_cfg.target_position = target_position_reg;
    assign drive_cfg.prop_gain       = prop_gain_reg;
    assign drive_cfg.deriv_gain      = deriv_gain_reg;
    assign drive_cfg.cruise_speed    = cruise_speed_reg;
    assign drive_cfg.spin_speed      = spin_speed_reg;
    assign drive_cfg.drive_limit     = drive_limit_reg;

    lfpd_front u_front (
        .sensor_valid (sensor_valid),
        .sensor_ready (sensor_ready),
        .samples      (samples),
        .on_threshold (on_threshold_reg),
        .fifo_full    (fifo_full),
        .push         (push),
        .item         (front_item)
    );

    lfpd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .valid     (fifo_valid),
        .head      (fifo_head)
    );

    lfpd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_valid    (fifo_valid),
        .fifo_head     (fifo_head),
        .fifo_pop      (fifo_pop),
        .cfg           (drive_cfg),
        .drive_valid   (drive_valid),
        .drive_ready   (drive_ready),
        .left_forward  (left_forward),
        .left_drive    (left_drive),
        .right_forward (right_forward),
        .right_drive   (right_drive),
        .drive_mode    (drive_mode),
        .sensors_on    (sensors_on)
    );

    // A stop result drives nothing.
    a_stop_is_still: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_valid && drive_mode == MODE_STOP) |->
        (left_drive == '0 && right_drive == '0 && !left_forward && !right_forward))
        else $error("stop result with nonzero drive");

    // Spinning turns in place: equal magnitudes, never both forward.
    a_spin_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_valid && drive_mode == MODE_SPIN) |->
        (left_drive == right_drive && !(left_forward && right_forward)))
        else $error("spin result not balanced");

    a_drive_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid |-> (left_drive <= drive_limit_reg && right_drive <= drive_limit_reg))
        else $error("motor magnitude above drive limit");

endmodule

// ===== bench/lfpd_drive_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the line follower PD drive unit: mirrors the register writes, predicts
// the motor command for every accepted sensor set and compares it with the unit's output.
// Depends on lfpd_pkg for widths, mode codes, register indexes and reset values.
module lfpd_drive_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            sensor_valid,
    input  logic                            sensor_ready,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]   sensor_0,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]   sensor_1,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]   sensor_2,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]   sensor_3,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]   sensor_4,
    input  logic                            drive_valid,
    input  logic                            drive_ready,
    input  logic                            left_forward,
    input  logic [lfpd_pkg::SPEED_W-1:0]    left_drive,
    input  logic                            right_forward,
    input  logic [lfpd_pkg::SPEED_W-1:0]    right_drive,
    input  logic [lfpd_pkg::MODE_W-1:0]     drive_mode,
    input  logic [lfpd_pkg::CNT_W-1:0]      sensors_on,
    output int                              errors,
    output int                              pending
);
    import lfpd_pkg::*;

    typedef struct packed {
        logic               left_fwd;
        logic [SPEED_W-1:0] left_mag;
        logic               right_fwd;
        logic [SPEED_W-1:0] right_mag;
        logic [MODE_W-1:0]  mode;
        logic [CNT_W-1:0]   count;
    } motor_cmd_t;

    // Register copies.
    logic [SAMPLE_W-1:0] thr_q;
    logic [POS_W-1:0]    target_q;
    logic [GAIN_W-1:0]   kp_q;
    logic [GAIN_W-1:0]   kd_q;
    logic [SPEED_W-1:0]  cruise_q;
    logic [SPEED_W-1:0]  spin_q;
    logic [SPEED_W-1:0]  limit_q;

    // Controller state.
    int                  prev_err;
    logic [POS_W-1:0]    position;
    logic [MODE_W-1:0]   mode;
    logic                side_right;

    motor_cmd_t motor_cmd_q[$];

    // Direction is forward only for a positive drive; the magnitude saturates at the limit.
    function automatic logic [SPEED_W:0] motor_out(input int v);
        int mag;
        int lim;
        begin
            lim = int'(limit_q);
            mag = (v > 0) ? v : -v;
            if (mag > lim)
                mag = lim;
            motor_out = {(v > 0), mag[SPEED_W-1:0]};
        end
    endfunction

    function automatic motor_cmd_t predict_drive(
        input logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0] s
    );
        logic [SENSOR_COUNT-1:0] on;
        int         total;
        int         wsum;
        int         err;
        int         pd;
        int         left;
        int         right;
        logic       run_pd;
        motor_cmd_t cmd;
        begin
            total  = 0;
            wsum   = 0;
            left   = 0;
            right  = 0;
            run_pd = 1'b0;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                on[i] = s[i] > thr_q;
                if (on[i])
                begin
                    total++;
                    wsum += i + 1;
                end
            end
            if (total != 0)
                position = POS_W'(wsum / total);

            case (mode)
                MODE_STOP:
                begin
                    if (total != 0)
                    begin
                        mode   = MODE_FOLLOW;
                        run_pd = 1'b1;
                    end
                end
                MODE_SPIN:
                begin
                    // Only the centre sensor ends a spin.
                    if (on[CENTRE_IDX])
                    begin
                        mode   = MODE_FOLLOW;
                        run_pd = 1'b1;
                    end
                end
                default:
                begin
                    mode = MODE_FOLLOW;
                    if (total == 0)
                        mode = MODE_STOP;
                    else if (total == SENSOR_COUNT)
                        mode = MODE_SPIN;
                    else
                        run_pd = 1'b1;
                end
            endcase

            if (run_pd)
            begin
                err      = int'(target_q) - int'(position);
                pd       = int'(kp_q) * err + int'(kd_q) * (err - prev_err);
                prev_err = err;
                left     = int'(cruise_q) + pd;
                right    = int'(cruise_q) - pd;
            end
            else if (mode == MODE_SPIN)
            begin
                if (side_right)
                begin
                    left  = int'(spin_q);
                    right = -int'(spin_q);
                end
                else
                begin
                    left  = -int'(spin_q);
                    right = int'(spin_q);
                end
            end

            // The side memory follows whichever outer sensor alone sees the line.
            if (on[SENSOR_COUNT-1] && !on[0])
                side_right = 1'b0;
            if (!on[SENSOR_COUNT-1] && on[0])
                side_right = 1'b1;

            {cmd.left_fwd, cmd.left_mag}   = motor_out(left);
            {cmd.right_fwd, cmd.right_mag} = motor_out(right);
            cmd.mode  = mode;
            cmd.count = total[CNT_W-1:0];
            predict_drive = cmd;
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        begin
            if (want != got)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        motor_cmd_t want;
        if (!rst_n)
        begin
            thr_q      = RST_ON_THRESHOLD;
            target_q   = RST_TARGET_POSITION;
            kp_q       = RST_PROP_GAIN;
            kd_q       = RST_DERIV_GAIN;
            cruise_q   = RST_CRUISE_SPEED;
            spin_q     = RST_SPIN_SPEED;
            limit_q    = RST_DRIVE_LIMIT;
            prev_err   = 0;
            position   = '0;
            mode       = MODE_FOLLOW;
            side_right = 1'b0;
            motor_cmd_q.delete();
            errors     = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_ON_THRESHOLD:    thr_q    = cfg_data[SAMPLE_W-1:0];
                    REG_TARGET_POSITION: target_q = cfg_data[POS_W-1:0];
                    REG_PROP_GAIN:       kp_q     = cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN:      kd_q     = cfg_data[GAIN_W-1:0];
                    REG_CRUISE_SPEED:    cruise_q = cfg_data[SPEED_W-1:0];
                    REG_SPIN_SPEED:      spin_q   = cfg_data[SPEED_W-1:0];
                    REG_DRIVE_LIMIT:     limit_q  = cfg_data[SPEED_W-1:0];
                    default:             ;
                endcase
            end

            if (sensor_valid && sensor_ready)
                motor_cmd_q.push_back(
                    predict_drive({sensor_4, sensor_3, sensor_2, sensor_1, sensor_0}));

            if (drive_valid && drive_ready)
            begin
                if (motor_cmd_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: drive item with none expected, actual mode %0d count %0d",
                             $time, drive_mode, sensors_on);
                end
                else
                begin
                    want = motor_cmd_q.pop_front();
                    check_field("left_forward", want.left_fwd, left_forward);
                    check_field("left_drive", want.left_mag, left_drive);
                    check_field("right_forward", want.right_fwd, right_forward);
                    check_field("right_drive", want.right_mag, right_drive);
                    check_field("drive_mode", want.mode, drive_mode);
                    check_field("sensors_on", want.count, sensors_on);
                end
            end
        end
        pending = motor_cmd_q.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top of the drive unit bench: clock, reset, register writes, sensor sets and result stalls.
// Depends on lfpd_pkg, line_follower_pd_drive_unit and lfpd_drive_checker.
module tb;
    import lfpd_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 135;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0] sensor_set_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  sensor_valid;
    logic                  sensor_ready;
    logic [SAMPLE_W-1:0]   sensor_0;
    logic [SAMPLE_W-1:0]   sensor_1;
    logic [SAMPLE_W-1:0]   sensor_2;
    logic [SAMPLE_W-1:0]   sensor_3;
    logic [SAMPLE_W-1:0]   sensor_4;
    logic                  drive_valid;
    logic                  drive_ready = 1'b0;
    logic                  left_forward;
    logic [SPEED_W-1:0]    left_drive;
    logic                  right_forward;
    logic [SPEED_W-1:0]    right_drive;
    logic [MODE_W-1:0]     drive_mode;
    logic [CNT_W-1:0]      sensors_on;

    int                    errors;
    int                    pending;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    quiet_cycles = 0;
    int                    hold_left = 0;
    logic                  hold_done = 1'b0;
    logic                  long_hold = 1'b0;
    logic [SAMPLE_W-1:0]   cur_thr;

    line_follower_pd_drive_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sensor_valid  (sensor_valid),
        .sensor_ready  (sensor_ready),
        .sensor_0      (sensor_0),
        .sensor_1      (sensor_1),
        .sensor_2      (sensor_2),
        .sensor_3      (sensor_3),
        .sensor_4      (sensor_4),
        .drive_valid   (drive_valid),
        .drive_ready   (drive_ready),
        .left_forward  (left_forward),
        .left_drive    (left_drive),
        .right_forward (right_forward),
        .right_drive   (right_drive),
        .drive_mode    (drive_mode),
        .sensors_on    (sensors_on)
    );

    lfpd_drive_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sensor_valid  (sensor_valid),
        .sensor_ready  (sensor_ready),
        .sensor_0      (sensor_0),
        .sensor_1      (sensor_1),
        .sensor_2      (sensor_2),
        .sensor_3      (sensor_3),
        .sensor_4      (sensor_4),
        .drive_valid   (drive_valid),
        .drive_ready   (drive_ready),
        .left_forward  (left_forward),
        .left_drive    (left_drive),
        .right_forward (right_forward),
        .right_drive   (right_drive),
        .drive_mode    (drive_mode),
        .sensors_on    (sensors_on),
        .errors        (errors),
        .pending       (pending)
    );

    always #2 clk = ~clk;

    // Result side: one long hold-off when asked for, otherwise random stalls.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            drive_ready = 1'b0;
            hold_left--;
        end
        else if (long_hold && !hold_done)
        begin
            hold_done   = 1'b1;
            hold_left   = LONG_HOLD - 1;
            drive_ready = 1'b0;
        end
        else
            drive_ready = !(stall_pct != 0 && $urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sensor_valid && sensor_ready) || (drive_valid && drive_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic sensor_set_t set_of(
        input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1,
        input logic [SAMPLE_W-1:0] s2, input logic [SAMPLE_W-1:0] s3,
        input logic [SAMPLE_W-1:0] s4
    );
        set_of = {s4, s3, s2, s1, s0};
    endfunction

    // Mostly a random on/off pattern placed either side of the threshold, with extra weight
    // on the all-off and all-on patterns that drive the stop and spin modes; some pure noise.
    function automatic sensor_set_t random_set(input logic [SAMPLE_W-1:0] thr);
        sensor_set_t             s;
        logic [SENSOR_COUNT-1:0] mask;
        int                      pick;
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                mask = '0;
            else if (pick < 27)
                mask = '1;
            else
                mask = SENSOR_COUNT'($urandom);
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                if (pick >= 90)
                    s[i] = SAMPLE_W'($urandom);
                else if (mask[i] && thr != '1)
                    s[i] = SAMPLE_W'($urandom_range(2 ** SAMPLE_W - 1, int'(thr) + 1));
                else
                    s[i] = SAMPLE_W'($urandom_range(int'(thr), 0));
            end
            random_set = s;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        if (idx == REG_ON_THRESHOLD)
            cur_thr = data[SAMPLE_W-1:0];
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_set(input sensor_set_t s);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            sensor_valid = 1'b0;
            @(negedge clk);
        end
        sensor_valid = 1'b1;
        {sensor_4, sensor_3, sensor_2, sensor_1, sensor_0} = s;
        @(posedge clk);
        while (!sensor_ready)
            @(posedge clk);
        @(negedge clk);
        sensor_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_phase_cfg(input int phase);
        case (phase)
            1:
            begin
                write_reg(REG_ON_THRESHOLD, 10'd512);
                write_reg(REG_TARGET_POSITION, '1);
                write_reg(REG_PROP_GAIN, '1);
                write_reg(REG_DERIV_GAIN, '1);
                write_reg(REG_CRUISE_SPEED, '1);
                write_reg(REG_SPIN_SPEED, '1);
                write_reg(REG_DRIVE_LIMIT, '1);
            end
            2:
            begin
                write_reg(REG_ON_THRESHOLD, '0);
                write_reg(REG_TARGET_POSITION, '0);
                write_reg(REG_PROP_GAIN, '0);
                write_reg(REG_DERIV_GAIN, '0);
                write_reg(REG_CRUISE_SPEED, '0);
                write_reg(REG_SPIN_SPEED, '0);
                write_reg(REG_DRIVE_LIMIT, '0);
            end
            default:
            begin
                // Upper data bits are random too; the narrow registers must drop them.
                write_reg(REG_ON_THRESHOLD, CFG_DATA_W'($urandom_range(923, 100)));
                write_reg(REG_TARGET_POSITION, CFG_DATA_W'($urandom));
                write_reg(REG_PROP_GAIN, CFG_DATA_W'($urandom));
                write_reg(REG_DERIV_GAIN, CFG_DATA_W'($urandom));
                write_reg(REG_CRUISE_SPEED, CFG_DATA_W'($urandom));
                write_reg(REG_SPIN_SPEED, CFG_DATA_W'($urandom));
                write_reg(REG_DRIVE_LIMIT, CFG_DATA_W'($urandom));
            end
        endcase
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sensor_valid = 1'b0;
        sensor_0     = '0;
        sensor_1     = '0;
        sensor_2     = '0;
        sensor_3     = '0;
        sensor_4     = '0;
        cur_thr      = RST_ON_THRESHOLD;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: stop and its repeat, return on any sensor, threshold edge,
        // spin both ways, spin held until the centre sees the line, assorted positions.
        send_set(set_of(0, 0, 0, 0, 0));
        send_set(set_of(0, 0, 0, 0, 0));
        send_set(set_of(0, 0, 601, 0, 0));
        send_set(set_of(601, 0, 600, 0, 0));
        send_set(set_of(1023, 1023, 1023, 1023, 1023));
        send_set(set_of(0, 0, 0, 0, 1023));
        send_set(set_of(0, 0, 0, 0, 0));
        send_set(set_of(0, 0, 1023, 0, 0));
        send_set(set_of(1023, 1023, 1023, 1023, 1023));
        send_set(set_of(1023, 1023, 1023, 1023, 1023));
        send_set(set_of(0, 1023, 0, 1023, 0));
        send_set(set_of(0, 0, 0, 1023, 1023));
        send_set(set_of(1023, 1023, 0, 0, 0));
        send_set(set_of(1023, 0, 0, 0, 1023));
        wait_drained();

        // Largest gains, speeds and limit with an out-of-range target.
        write_reg(REG_TARGET_POSITION, 10'd7);
        write_reg(REG_PROP_GAIN, 10'd1023);
        write_reg(REG_DERIV_GAIN, 10'd1023);
        write_reg(REG_CRUISE_SPEED, 10'd255);
        write_reg(REG_SPIN_SPEED, 10'd255);
        write_reg(REG_DRIVE_LIMIT, 10'd255);
        send_set(set_of(1023, 0, 0, 0, 0));
        send_set(set_of(0, 0, 0, 0, 1023));
        send_set(set_of(1023, 1023, 1023, 1023, 1023));
        send_set(set_of(0, 0, 1023, 0, 0));
        wait_drained();

        // Highest threshold: no sample can count as on. Zero limit, ignored index.
        write_reg(REG_ON_THRESHOLD, 10'd1023);
        write_reg(REG_DRIVE_LIMIT, 10'd0);
        write_reg(REG_TARGET_POSITION, 10'd0);
        write_reg(REG_SPARE, 10'd1023);
        send_set(set_of(1023, 1023, 1023, 1023, 1023));
        send_set(set_of(0, 1023, 0, 0, 0));
        wait_drained();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 81; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            load_phase_cfg(phase);
            // Block the result side for a long stretch while items keep coming.
            if (phase == 4)
            begin
                @(posedge clk);
                long_hold = 1'b1;
                @(negedge clk);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_set(random_set(cur_thr));
            wait_drained();
        end

        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== line_follower_pd_drive_unit.f =====
rtl/core/lfpd_pkg.sv
rtl/core/lfpd_front.sv
rtl/core/lfpd_fifo.sv
rtl/core/lfpd_div.sv
rtl/core/lfpd_back.sv
rtl/core/line_follower_pd_drive_unit.sv
bench/lfpd_drive_checker.sv
bench/tb.sv
